// ===== src/bhpq_pkg.sv =====
// Shared types, codes and the key ordering function of the binary heap queue.
// Used by bhpq_ctrl, bhpq_dp and binary_heap_priority_queue; depends on nothing.
`default_nettype none
package bhpq_pkg;

  localparam int KeyW = 32;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [2:0]             opc_t;
  typedef logic [2:0]             stc_t;
  typedef logic [4:0]             cmd_t;

  // Operation codes
  localparam opc_t OP_INS  = 3'd0;
  localparam opc_t OP_EXT  = 3'd1;
  localparam opc_t OP_EXTK = 3'd2;
  localparam opc_t OP_REP  = 3'd3;
  localparam opc_t OP_DEL  = 3'd4;

  // Status codes
  localparam stc_t ST_OK    = 3'd0;
  localparam stc_t ST_FULL  = 3'd1;
  localparam stc_t ST_EMPTY = 3'd2;
  localparam stc_t ST_RANK  = 3'd3;
  localparam stc_t ST_INDEX = 3'd4;

  // Datapath commands
  localparam cmd_t C_NOP    = 5'd0;
  localparam cmd_t C_LOAD   = 5'd1;
  localparam cmd_t C_INS    = 5'd2;
  localparam cmd_t C_REP    = 5'd3;
  localparam cmd_t C_DEL    = 5'd4;
  localparam cmd_t C_SETR   = 5'd5;
  localparam cmd_t C_RDPAR  = 5'd6;
  localparam cmd_t C_MVDN   = 5'd7;
  localparam cmd_t C_WRKEY  = 5'd8;
  localparam cmd_t C_RDROOT = 5'd9;
  localparam cmd_t C_TOPV   = 5'd10;
  localparam cmd_t C_DEC    = 5'd11;
  localparam cmd_t C_MKEY   = 5'd12;
  localparam cmd_t C_CANDL  = 5'd13;
  localparam cmd_t C_CANDR  = 5'd14;
  localparam cmd_t C_FIN    = 5'd15;

  // Status flags from datapath to controller
  typedef struct packed {
    logic err;
    opc_t op;
    logic pos_zero;
    logic fill_one;
    logic rank_last;
    logic rank_zero;
    logic up_better;
    logic dn_move;
  } stat_t;

  // True when a belongs strictly above b.
  function automatic logic better(input key_t a, input key_t b, input logic omin);
    return omin ? (a < b) : (a > b);
  endfunction

endpackage
`default_nettype wire

// ===== src/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue: configuration register and wiring.
// Depends on bhpq_pkg, bhpq_ctrl, bhpq_dp and bhpq_ram.
`default_nettype none
// Usage
// An item is taken at a rising edge where start is high and busy is low; op selects
// insert, extract top, extract k-th, replace or delete, with key, index and rank as
// operands. Each item produces exactly one result: done is high for a single cycle,
// and value, status and count are set with it and held until the next result. The
// receiver cannot stall, so the result must be captured in that cycle. busy falls
// in the cycle in which done is high, so the next item can be accepted at the edge
// that ends the result cycle; items are handled one at a time.
// The key store has a single read port and a single write port, so an item walks
// through states. Each level of a sift-up passes through S_UP and S_UPC, each level
// of a sift-down through S_DNR and S_DNC, and each removal of a top through S_POP,
// S_POPT, S_POP2 and S_DNM before its sift-down begins. An extract k-th removes the
// top k times, and an item that fails its range check goes from dispatch straight
// to the result.
// Reset empties the queue and selects largest-on-top order. Only entries below the
// fill are read, so the store needs no clearing. The user writes the order register
// (bit 0 at address 0 of the APB port) only while idle; the block does not check.
module binary_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] key,
  input  wire logic [9:0]         index,
  input  wire logic [10:0]        rank,
  output logic                    done,
  output logic signed [31:0]      value,
  output logic [2:0]              status,
  output logic [10:0]             count,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic            order_min;
  bhpq_pkg::cmd_t  cmd;
  bhpq_pkg::stat_t st;

  // The port never waits; register 0 occupies the first word.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, order_min} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_min <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      order_min <= pwdata[0];
    end
  end

  bhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  bhpq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .order_min (order_min),
    .op        (op),
    .key       (key),
    .index     (index),
    .rank      (rank),
    .st        (st),
    .done      (done),
    .value     (value),
    .status    (status),
    .count     (count)
  );

endmodule
`default_nettype wire

// ===== src/bhpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package needed.
`default_nettype none
module bhpq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/bhpq_ctrl.sv =====
// Sequencer of the heap queue: walks each operation through datapath commands.
// Depends on bhpq_pkg.
`default_nettype none
module bhpq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire bhpq_pkg::stat_t st,
  output bhpq_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_UP   = 4'd2;
  localparam logic [3:0] S_UPC  = 4'd3;
  localparam logic [3:0] S_DELV = 4'd4;
  localparam logic [3:0] S_DELU = 4'd5;
  localparam logic [3:0] S_DELM = 4'd6;
  localparam logic [3:0] S_POP  = 4'd7;
  localparam logic [3:0] S_POPT = 4'd8;
  localparam logic [3:0] S_POP2 = 4'd9;
  localparam logic [3:0] S_DNM  = 4'd10;
  localparam logic [3:0] S_DNR  = 4'd11;
  localparam logic [3:0] S_DNC  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = bhpq_pkg::C_NOP;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd        = bhpq_pkg::C_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.err) begin
          state_next = S_FIN;
        end else begin
          case (st.op)
            bhpq_pkg::OP_INS: begin
              cmd        = bhpq_pkg::C_INS;
              state_next = S_UP;
            end
            bhpq_pkg::OP_REP: begin
              cmd        = bhpq_pkg::C_REP;
              state_next = S_UP;
            end
            bhpq_pkg::OP_EXT, bhpq_pkg::OP_EXTK: begin
              cmd        = bhpq_pkg::C_SETR;
              state_next = S_POP;
            end
            bhpq_pkg::OP_DEL: begin
              cmd        = bhpq_pkg::C_DEL;
              state_next = S_DELV;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_UP: begin
        if (st.pos_zero) begin
          cmd        = bhpq_pkg::C_WRKEY;
          state_next = S_FIN;
        end else begin
          cmd        = bhpq_pkg::C_RDPAR;
          state_next = S_UPC;
        end
      end
      S_UPC: begin
        if (st.up_better) begin
          cmd        = bhpq_pkg::C_MVDN;
          state_next = S_UP;
        end else begin
          cmd        = bhpq_pkg::C_WRKEY;
          state_next = S_FIN;
        end
      end
      S_DELV: begin
        cmd        = bhpq_pkg::C_TOPV;
        state_next = S_DELU;
      end
      S_DELU: begin
        if (st.pos_zero) begin
          state_next = S_POP2;
        end else begin
          cmd        = bhpq_pkg::C_RDPAR;
          state_next = S_DELM;
        end
      end
      S_DELM: begin
        cmd        = bhpq_pkg::C_MVDN;
        state_next = S_DELU;
      end
      S_POP: begin
        cmd        = bhpq_pkg::C_RDROOT;
        state_next = S_POPT;
      end
      S_POPT: begin
        cmd        = bhpq_pkg::C_TOPV;
        state_next = S_POP2;
      end
      S_POP2: begin
        cmd = bhpq_pkg::C_DEC;
        if (st.fill_one) begin
          state_next = st.rank_last ? S_FIN : S_POP;
        end else begin
          state_next = S_DNM;
        end
      end
      S_DNM: begin
        cmd        = bhpq_pkg::C_MKEY;
        state_next = S_DNR;
      end
      S_DNR: begin
        cmd        = bhpq_pkg::C_CANDL;
        state_next = S_DNC;
      end
      S_DNC: begin
        cmd = bhpq_pkg::C_CANDR;
        if (st.dn_move) begin
          state_next = S_DNR;
        end else begin
          state_next = st.rank_zero ? S_FIN : S_POP;
        end
      end
      S_FIN: begin
        cmd        = bhpq_pkg::C_FIN;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/bhpq_dp.sv =====
// Datapath of the heap queue: key store, moving key, positions, fill count and result.
// Depends on bhpq_pkg and bhpq_ram.
`default_nettype none
module bhpq_dp #(
  parameter int CAPACITY = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bhpq_pkg::cmd_t cmd,
  input  wire logic           order_min,
  input  wire logic [2:0]     op,
  input  wire logic signed [31:0] key,
  input  wire logic [9:0]     index,
  input  wire logic [10:0]    rank,
  output bhpq_pkg::stat_t     st,
  output logic                done,
  output logic signed [31:0]  value,
  output logic [2:0]          status,
  output logic [10:0]         count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;
  localparam int RW = (CW > 11) ? CW : 11;
  localparam int XW = (CW > 10) ? CW : 10;

  logic [CW-1:0]      fill;
  logic [AW-1:0]      pos, cand_pos;
  bhpq_pkg::key_t     mkey, cand_val, top_val, key_r;
  logic               cand_has;
  logic [10:0]        rank_left, rank_r;
  logic [9:0]         idx_r;
  bhpq_pkg::opc_t     op_r;
  bhpq_pkg::stc_t     st_r, st_in;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  bhpq_pkg::key_t     ram_wdata, rd_data;

  logic [AW-1:0]      parent;
  logic [LW-1:0]      left_w, right_w, next_left;
  logic               l_ok, r_ok, r_take, move;
  logic [AW-1:0]      sel_pos;
  bhpq_pkg::key_t     sel_val, r_ref;

  bhpq_ram #(.Width(bhpq_pkg::KeyW), .Depth(CAPACITY)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign left_w  = LW'({pos, 1'b1});
  assign right_w = left_w + LW'(1);
  assign l_ok    = left_w < LW'(fill);
  assign r_ok    = right_w < LW'(fill);
  assign r_ref   = cand_has ? cand_val : mkey;
  assign r_take  = r_ok && bhpq_pkg::better(rd_data, r_ref, order_min);
  assign move    = r_take || cand_has;
  assign sel_pos = r_take ? AW'(right_w) : cand_pos;
  assign sel_val = r_take ? rd_data : cand_val;
  assign next_left = LW'({sel_pos, 1'b1});

  // Range checks for the incoming item against the current fill.
  always_comb begin
    case (op)
      bhpq_pkg::OP_INS:
        st_in = (fill == CW'(CAPACITY)) ? bhpq_pkg::ST_FULL : bhpq_pkg::ST_OK;
      bhpq_pkg::OP_EXT:
        st_in = (fill == '0) ? bhpq_pkg::ST_EMPTY : bhpq_pkg::ST_OK;
      bhpq_pkg::OP_EXTK:
        st_in = (rank == '0 || RW'(rank) > RW'(fill)) ? bhpq_pkg::ST_RANK
                                                      : bhpq_pkg::ST_OK;
      bhpq_pkg::OP_REP, bhpq_pkg::OP_DEL:
        st_in = (XW'(index) >= XW'(fill)) ? bhpq_pkg::ST_INDEX : bhpq_pkg::ST_OK;
      default: st_in = bhpq_pkg::ST_OK;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = mkey;
    ram_raddr = '0;
    case (cmd)
      bhpq_pkg::C_DEL:   ram_raddr = AW'(idx_r);
      bhpq_pkg::C_RDPAR: ram_raddr = parent;
      bhpq_pkg::C_MVDN: begin
        ram_we    = 1'b1;
        ram_wdata = rd_data;
      end
      bhpq_pkg::C_WRKEY: ram_we = 1'b1;
      bhpq_pkg::C_DEC:   ram_raddr = AW'(fill - CW'(1));
      bhpq_pkg::C_MKEY:  ram_raddr = AW'(left_w);
      bhpq_pkg::C_CANDL: ram_raddr = AW'(right_w);
      bhpq_pkg::C_CANDR: begin
        ram_we    = 1'b1;
        ram_wdata = move ? sel_val : mkey;
        ram_raddr = AW'(next_left);
      end
      default: ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      done <= (cmd == bhpq_pkg::C_FIN);
      case (cmd)
        bhpq_pkg::C_INS: fill <= fill + CW'(1);
        bhpq_pkg::C_DEC: fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      bhpq_pkg::C_LOAD: begin
        op_r    <= op;
        key_r   <= key;
        idx_r   <= index;
        rank_r  <= rank;
        st_r    <= st_in;
        top_val <= '0;
      end
      bhpq_pkg::C_INS: begin
        pos  <= AW'(fill);
        mkey <= key_r;
      end
      bhpq_pkg::C_REP: begin
        pos  <= AW'(idx_r);
        mkey <= key_r;
      end
      bhpq_pkg::C_DEL: begin
        pos       <= AW'(idx_r);
        rank_left <= 11'd1;
      end
      bhpq_pkg::C_SETR: rank_left <= (op_r == bhpq_pkg::OP_EXTK) ? rank_r : 11'd1;
      bhpq_pkg::C_MVDN: pos <= parent;
      bhpq_pkg::C_TOPV: top_val <= rd_data;
      bhpq_pkg::C_DEC: begin
        rank_left <= rank_left - 11'd1;
        pos       <= '0;
      end
      bhpq_pkg::C_MKEY: mkey <= rd_data;
      bhpq_pkg::C_CANDL: begin
        cand_has <= l_ok && bhpq_pkg::better(rd_data, mkey, order_min);
        cand_val <= rd_data;
        cand_pos <= AW'(left_w);
      end
      bhpq_pkg::C_CANDR: begin
        if (move) begin
          pos <= sel_pos;
        end
      end
      bhpq_pkg::C_FIN: begin
        value  <= top_val;
        status <= st_r;
        count  <= 11'(fill);
      end
      default: pos <= pos;
    endcase
  end

  always_comb begin
    st.err       = (st_r != bhpq_pkg::ST_OK);
    st.op        = op_r;
    st.pos_zero  = (pos == '0);
    st.fill_one  = (fill == CW'(1));
    st.rank_last = (rank_left == 11'd1);
    st.rank_zero = (rank_left == '0);
    st.up_better = bhpq_pkg::better(mkey, rd_data, order_min);
    st.dn_move   = move;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && status == bhpq_pkg::ST_FULL |-> fill == CW'(CAPACITY))
    else $error("full status reported while not full");

endmodule
`default_nettype wire
